// File: hw/rtl/itrd_pkg.sv
// itrd_pkg: shared types and constants for the integer to radix digit converter.
// No dependencies.
`default_nettype none

package itrd_pkg;

    localparam int VALUE_W  = 32;
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 7;
    localparam int STORE_DEPTH = 32;
    localparam int ADDR_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int BYTE_W   = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;   // '0'
    localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h61;   // 'a'

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_digit;
    } digit_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/integer_to_radix_digits.sv
// integer_to_radix_digits: 32-bit value to lower-case ASCII digits in radix 2..36.
// Depends on itrd_pkg and itrd_div_step.
//
// Each digit of the value comes from four uses of the byte-wide divide
// step; once division ends, each digit beat is a store read, then present.
// The input stalls from the item beat until the last digit beat is taken,
// so a new item is not taken while one is in progress; the divide step and
// the single store read port set the rate. Reset clears the sequencer and
// counters; the digit store is not cleared.
`default_nettype none

module integer_to_radix_digits (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  itrd_pkg::item_t item,
    output logic            digit_valid,
    input  logic            digit_stall,
    output itrd_pkg::digit_t digit
);
    import itrd_pkg::*;

    localparam int STEPS  = VALUE_W / BYTE_W;
    localparam int STEP_W = $clog2(STEPS);

    state_t state_reg, state_next;

    // running quotient, shifted a byte per step; after STEPS steps it holds
    // the full quotient of the digit just produced
    logic [VALUE_W-1:0]          quot_reg, quot_next;
    logic [RADIX_W-1:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [RADIX_W-1:0]          base_reg, base_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                        last_reg, last_next;
    logic [RADIX_W-1:0]          rd_data_reg;

    logic [RADIX_W-1:0]          store_mem [STORE_DEPTH];

    logic [RADIX_W-1:0]          rem_step;
    logic [BYTE_W-1:0]           quo_byte;
    logic [VALUE_W-1:0]          quot_shift;
    logic                        last_step;
    logic                        div_done;
    logic                        store_we;
    logic                        rd_en;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        b = r;
        if (r < RADIX_MIN)
            b = RADIX_MIN;
        else if (r > RADIX_MAX)
            b = RADIX_MAX;
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10)
            c = CHAR_ZERO + {1'b0, d};
        else
            c = CHAR_A + {1'b0, d} - 7'd10;
        return c;
    endfunction

    itrd_div_step u_div_step (
        .base     (base_reg),
        .rem_in   (rem_reg),
        .num_byte (quot_reg[VALUE_W-1 -: BYTE_W]),
        .rem_out  (rem_step),
        .quo_byte (quo_byte)
    );

    assign quot_shift = {quot_reg[VALUE_W-BYTE_W-1:0], quo_byte};
    assign last_step  = (step_reg == STEP_W'(STEPS - 1));
    // stop when the quotient runs out or the store is full
    assign div_done   = last_step &&
                        ((quot_shift == '0) || (count_reg == COUNT_W'(STORE_DEPTH - 1)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (item_valid)
                    state_next = S_DIV;
            S_DIV:
                if (div_done)
                    state_next = S_READ;
            S_READ:
                state_next = S_EMIT;
            S_EMIT:
                if (!digit_stall)
                    state_next = last_reg ? S_IDLE : S_READ;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb
    begin
        item_stall        = (state_reg != S_IDLE);
        digit_valid       = (state_reg == S_EMIT);
        store_we          = (state_reg == S_DIV) && last_step;
        rd_en             = (state_reg == S_READ);
        digit.char_code   = digit_char(rd_data_reg);
        digit.last_digit  = last_reg;
    end

    // datapath next values
    always_comb
    begin
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE:
                if (item_valid)
                begin
                    quot_next  = item.value;
                    rem_next   = '0;
                    step_next  = '0;
                    base_next  = clamp_radix(item.radix);
                    count_next = '0;
                end
            S_DIV:
            begin
                quot_next = quot_shift;
                step_next = step_reg + 1'b1;
                rem_next  = rem_step;
                if (last_step)
                begin
                    rem_next   = '0;
                    count_next = count_reg + 1'b1;
                end
                // most significant digit sits at the last written slot
                if (div_done)
                    rd_idx_next = count_reg[ADDR_W-1:0];
            end
            S_READ:
                last_next = (rd_idx_reg == '0);
            S_EMIT:
                if (!digit_stall && !last_reg)
                    rd_idx_next = rd_idx_reg - 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            quot_reg   <= '0;
            count_reg  <= '0;
            step_reg   <= '0;
            last_reg   <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            quot_reg   <= quot_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            last_reg   <= last_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    // digit store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[count_reg[ADDR_W-1:0]] <= rem_step;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= store_mem[rd_idx_reg];
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STORE_DEPTH))
        else $error("digit count beyond store depth");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> state_reg == S_DIV && step_reg == '0)
        else $error("item beat did not start division");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && !digit_stall && digit.last_digit |=> !item_stall)
        else $error("input still stalled after final digit");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < base_reg && base_reg >= RADIX_MIN
                               && base_reg <= RADIX_MAX)
        else $error("remainder or radix out of range");

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> count_reg != '0 && rd_idx_reg < count_reg[ADDR_W:0])
        else $error("store read past written digits");

endmodule

`default_nettype wire

// File: hw/rtl/itrd_div_step.sv
// itrd_div_step: divides one byte of the running quotient by the radix,
// eight restoring steps on a narrow remainder. Depends on itrd_pkg.
`default_nettype none

module itrd_div_step (
    input  logic [itrd_pkg::RADIX_W-1:0] base,
    input  logic [itrd_pkg::RADIX_W-1:0] rem_in,
    input  logic [itrd_pkg::BYTE_W-1:0]  num_byte,
    output logic [itrd_pkg::RADIX_W-1:0] rem_out,
    output logic [itrd_pkg::BYTE_W-1:0]  quo_byte
);
    import itrd_pkg::*;

    // rem_in < base, so the shifted partial remainder fits one extra bit
    always_comb
    begin
        logic [RADIX_W:0] r;
        r        = {1'b0, rem_in};
        quo_byte = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            r = {r[RADIX_W-1:0], num_byte[i]};
            if (r >= {1'b0, base})
            begin
                r           = r - {1'b0, base};
                quo_byte[i] = 1'b1;
            end
        end
        rem_out = r[RADIX_W-1:0];
    end

endmodule

`default_nettype wire

// File: test/integer_to_radix_digits_tb.sv
// integer_to_radix_digits_tb: self-checking bench for the radix digit converter.
// Depends on itrd_pkg and the integer_to_radix_digits RTL; nothing else.
module integer_to_radix_digits_tb;
    import itrd_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 5;
    // Random items after the directed block; about 230 beats in all.
    localparam int RANDOM_ITEMS = 208;
    // Idle pattern by count of accepted item beats: sender light/receiver
    // heavy, then swapped, then no random idling at all.
    localparam int PHASE1_END   = 90;
    localparam int PHASE2_END   = 160;
    // Receiver hold-off in the quiet phase; longer than one worst-case item,
    // so the block fills and must stall its input.
    localparam int HOLD_AT      = 175;
    localparam int HOLD_CYCLES  = 450;
    // Drain time, well past the worst-case first digit.
    localparam int DRAIN_CYCLES = 300;
    // Timeout for 230 items of up to 32 digits under heavy stalls.
    localparam int TIMEOUT_CYCLES = 600000;

    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     item_valid  = 1'b0;
    logic     item_stall;
    item_t    item        = '0;
    logic     digit_valid;
    logic     digit_stall = 1'b0;
    digit_t   digit;

    item_t    items_to_send [$];   // beats not yet offered
    digit_t   expected_digits [$]; // predicted digit beats, oldest first
    int       items_taken;
    int       digit_errors = 0;
    int       hold_left;
    logic     hold_done;

    integer_to_radix_digits DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digit predictor. Out-of-range radix clamps to 2..36, the value is
    // always unsigned, and zero gives a single '0'. Digits come out least
    // significant first from the division, then get queued in reverse.
    // ------------------------------------------------------------------
    function automatic void predict_digits(input item_t it);
        logic [VALUE_W-1:0] quotient;
        int unsigned        base;
        logic [RADIX_W-1:0] low_first [$];
        logic [RADIX_W-1:0] d;
        digit_t             beat;
        base = 32'(it.radix);
        if (base < 32'(RADIX_MIN))
            base = 32'(RADIX_MIN);
        if (base > 32'(RADIX_MAX))
            base = 32'(RADIX_MAX);
        quotient = it.value;
        if (quotient == '0)
            low_first.push_back('0);
        while (quotient != '0)
        begin
            low_first.push_back(RADIX_W'(quotient % base));
            quotient = quotient / base;
        end
        for (int k = low_first.size() - 1; k >= 0; k--)
        begin
            d = low_first[k];
            beat.char_code  = (d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - 10);
            beat.last_digit = (k == 0);
            expected_digits.push_back(beat);
        end
    endfunction

    function automatic void queue_item(input logic [VALUE_W-1:0] v,
                                       input logic [RADIX_W-1:0] r);
        item_t it;
        it.value = v;
        it.radix = r;
        items_to_send.push_back(it);
    endfunction

    function automatic int sender_idle_pct(input int taken);
        if (taken < PHASE1_END)
            return 20;
        if (taken < PHASE2_END)
            return 68;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(input int taken);
        if (taken < PHASE1_END)
            return 68;
        if (taken < PHASE2_END)
            return 20;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the next queued item, holds a stalled beat steady, and
    // predicts the digits of each beat the block takes.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            item        <= '0;
            items_taken <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_digits(item);
                items_taken <= items_taken + 1;
            end
            // new beat only when the line is free or the last one went in
            if (!item_valid || !item_stall)
            begin
                if (items_to_send.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct(items_taken))
                begin
                    item_valid <= 1'b1;
                    item       <= items_to_send.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off, counted here; fires once during the quiet phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_taken == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted digit beat against the oldest
    // prediction and drives the receiver stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        digit_t want;
        if (!rst_n)
        begin
            digit_stall <= 1'b0;
        end
        else
        begin
            if (digit_valid && !digit_stall)
            begin
                if (expected_digits.size() == 0)
                begin
                    $display("%0t: unexpected digit beat char_code %h last_digit %b",
                             $time, digit.char_code, digit.last_digit);
                    digit_errors++;
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (digit.char_code !== want.char_code)
                    begin
                        $display("%0t: char_code expected %h got %h",
                                 $time, want.char_code, digit.char_code);
                        digit_errors++;
                    end
                    if (digit.last_digit !== want.last_digit)
                    begin
                        $display("%0t: last_digit expected %b got %b",
                                 $time, want.last_digit, digit.last_digit);
                        digit_errors++;
                    end
                end
            end
            digit_stall <= (hold_left != 0) ||
                           ($urandom_range(0, 99) < receiver_idle_pct(items_taken));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        logic [VALUE_W-1:0] v;
        logic [RADIX_W-1:0] r;

        // directed: zero, extremes of both fields, clamped radixes,
        // top-bit-set patterns, first and last letter digits
        queue_item(32'h0000_0000, 6'd10);
        queue_item(32'h0000_0000, 6'd0);
        queue_item(32'h0000_0000, 6'd63);
        queue_item(32'hFFFF_FFFF, 6'd2);   // 32 digits, the longest run
        queue_item(32'hFFFF_FFFF, 6'd36);
        queue_item(32'hFFFF_FFFF, 6'd10);
        queue_item(32'h8000_0000, 6'd2);
        queue_item(32'h8000_0000, 6'd16);
        queue_item(32'h7FFF_FFFF, 6'd10);
        queue_item(32'h7FFF_FFFF, 6'd2);
        queue_item(32'h0000_0001, 6'd2);
        queue_item(32'h0000_0023, 6'd36);  // 'z'
        queue_item(32'h0000_000A, 6'd11);  // 'a'
        queue_item(32'h0000_00FF, 6'd0);   // below range, acts as 2
        queue_item(32'h0000_00FF, 6'd1);
        queue_item(32'h0000_04D2, 6'd37);  // above range, acts as 36
        queue_item(32'hDEAD_BEEF, 6'd63);
        queue_item(32'h1234_5678, 6'd8);
        queue_item(32'h0000_0023, 6'd35);
        queue_item(32'h5555_5555, 6'd3);
        queue_item(32'hAAAA_AAAA, 6'd7);
        queue_item(32'h0000_0024, 6'd36);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                v = $urandom;
            else if (pick < 70)
                v = $urandom_range(0, 99);
            else if (pick < 85)
                v = $urandom >> $urandom_range(0, 31);
            else
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            if ($urandom_range(0, 99) < 85)
                r = RADIX_W'($urandom_range(2, 36));
            else
                r = RADIX_W'($urandom_range(0, 63));
            queue_item(v, r);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // sample away from the edge so driver/monitor updates have settled
        do
            @(negedge clk);
        while (items_to_send.size() != 0 || item_valid || expected_digits.size() != 0);

        repeat (DRAIN_CYCLES) @(negedge clk);

        if (digit_errors == 0 && expected_digits.size() == 0)
            $display("integer_to_radix_digits_tb OK");
        else
            $display("integer_to_radix_digits_tb NOT OK");
        $finish;
    end

    initial
    begin
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("integer_to_radix_digits_tb NOT OK");
        $finish;
    end

endmodule
